// File: rtl/core/recency_replacement_policy_assert.svh
// Assertion helpers for the replacement policy block.
`ifndef RECENCY_REPLACEMENT_POLICY_ASSERT_SVH
`define RECENCY_REPLACEMENT_POLICY_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RRP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rrp assertion failed");

// Next-cycle implication.
`define RRP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rrp assertion failed");

`endif

// File: rtl/core/rrp_pkg.sv
package rrp_pkg;

   typedef enum logic [1:0] {
      CMD_REF   = 2'd0,
      CMD_EVICT = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_UPDATE,
      ST_SCAN,
      ST_RESULT
   } state_type;

endpackage

// File: rtl/core/recency_replacement_policy.sv
// Channel   Dir  Ports               Contents
// req       in   req_tvalid/tready   tuser: cmd[1:0]; tdata: way[2:0], zero pad
// rsp       out  rsp_tvalid/tready   tdata: victim_way[2:0], next_way[5:3],
//                                           stamp_wrapped[6], zero pad
// csr       in   csr_we/csr_wdata    select_mode
//
// Reference, clear and unused requests walk the stamp memory once; evict walks it twice.
// One stamp comparator walks the one-read-port stamp memory, once to find the
// victim (evict only) and once for the next victim.
// Reset is synchronous: all stamps read as zero, counter and mode cleared.
// A finished result sits in the output register while the next request is taken;
// a stalled output holds the block in its result state.
module recency_replacement_policy #(
   parameter int WAYS       = 8,
   parameter int STAMP_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,   // cmd[1:0]
   input  logic [7:0] req_tdata,   // way[2:0], zero pad[7:3]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // victim_way[2:0], next_way[5:3], stamp_wrapped[6]
   input  logic       csr_we,
   input  logic       csr_wdata    // select_mode
);

`include "recency_replacement_policy_assert.svh"

   localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CW = $clog2(WAYS + 1);

   rrp_pkg::state_type state_ff, state_in;
   rrp_pkg::cmd_type   cmd_ff, cmd_in;
   logic [2:0]            way_ff, way_in;
   logic                  mode_ff;
   logic [STAMP_BITS-1:0] ctr_ff, ctr_in;
   logic [WAYS-1:0]       valid_ff, valid_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [IW-1:0]         rd_idx_ff, rd_idx_in;
   logic [STAMP_BITS-1:0] mem_q_ff;
   logic                  rd_vld_ff;
   logic [IW-1:0]         best_ff, best_in;
   logic [STAMP_BITS-1:0] best_stamp_ff, best_stamp_in;
   logic [IW-1:0]         victim_ff, victim_in;
   logic                  wrap_ff, wrap_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;

   logic [STAMP_BITS-1:0] stamp_mem [WAYS];
   logic                  mem_we;
   logic [IW-1:0]         mem_wa;
   logic [IW-1:0]         mem_ra;

   logic [IW+2:0]         way_wide;
   logic                  way_in_range;
   logic [STAMP_BITS-1:0] cand;
   logic                  better;
   logic [IW+2:0]         best_wide;
   logic [IW+2:0]         victim_wide;
   logic                  scanning;
   logic                  scan_end;
   logic                  in_update;
   logic                  upd_clear;
   logic                  upd_bad_ref;

   assign way_wide     = {{IW{1'b0}}, way_ff};
   assign way_in_range = way_wide < (IW+3)'(WAYS);
   assign best_wide    = {3'b000, best_ff};
   assign victim_wide  = {3'b000, victim_ff};
   assign scanning     = (state_ff == rrp_pkg::ST_FIND) || (state_ff == rrp_pkg::ST_SCAN);
   assign scan_end     = scanning && (cnt_ff == CW'(WAYS));
   assign in_update    = (state_ff == rrp_pkg::ST_UPDATE);
   assign upd_clear    = in_update && (cmd_ff == rrp_pkg::CMD_CLEAR);
   assign upd_bad_ref  = in_update && (cmd_ff == rrp_pkg::CMD_REF) && !way_in_range;

   // shared comparator; a never-written stamp reads as zero
   assign cand   = rd_vld_ff ? mem_q_ff : '0;
   assign better = (rd_idx_ff == '0) ||
                   (mode_ff ? (cand > best_stamp_ff) : (cand < best_stamp_ff));

   assign req_tready = (state_ff == rrp_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrp_pkg::ST_IDLE;
         mode_ff      <= 1'b0;
         ctr_ff       <= '0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      way_ff        <= way_in;
      rd_idx_ff     <= rd_idx_in;
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
      victim_ff     <= victim_in;
      wrap_ff       <= wrap_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // stamp memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[mem_wa] <= ctr_ff;
      end
      mem_q_ff  <= stamp_mem[mem_ra];
      rd_vld_ff <= valid_ff[mem_ra];
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      way_in        = way_ff;
      ctr_in        = ctr_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = cnt_ff[IW-1:0];
      mem_ra        = cnt_ff[IW-1:0];
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;
      victim_in     = victim_ff;
      wrap_in       = wrap_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = best_ff;

      // output register drains independently of the sequencer
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (scanning) begin
         if (cnt_ff != CW'(WAYS)) begin
            rd_pend_in = 1'b1;
            cnt_in     = cnt_ff + CW'(1);
         end
         if (rd_pend_ff && better) begin
            best_in       = rd_idx_ff;
            best_stamp_in = cand;
         end
      end

      unique case (state_ff)
         rrp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = rrp_pkg::cmd_type'(req_tuser);
               way_in   = req_tdata[2:0];
               wrap_in  = 1'b0;
               victim_in = '0;
               cnt_in   = '0;
               state_in = (rrp_pkg::cmd_type'(req_tuser) == rrp_pkg::CMD_EVICT) ?
                          rrp_pkg::ST_FIND : rrp_pkg::ST_UPDATE;
            end
         end
         rrp_pkg::ST_FIND: begin
            if (scan_end) begin
               state_in = rrp_pkg::ST_UPDATE;
            end
         end
         rrp_pkg::ST_UPDATE: begin
            cnt_in   = '0;
            state_in = rrp_pkg::ST_SCAN;
            case (cmd_ff)
               rrp_pkg::CMD_REF: begin
                  if (way_in_range) begin
                     mem_we            = 1'b1;
                     mem_wa            = way_wide[IW-1:0];
                     valid_in[mem_wa]  = 1'b1;
                     ctr_in            = ctr_ff + STAMP_BITS'(1);
                     wrap_in           = (ctr_in == '0);
                  end
               end
               rrp_pkg::CMD_EVICT: begin
                  mem_we           = 1'b1;
                  mem_wa           = best_ff;
                  valid_in[mem_wa] = 1'b1;
                  victim_in        = best_ff;
                  ctr_in           = ctr_ff + STAMP_BITS'(1);
                  wrap_in          = (ctr_in == '0);
               end
               rrp_pkg::CMD_CLEAR: begin
                  valid_in = '0;
                  ctr_in   = '0;
               end
               default: begin
               end
            endcase
         end
         rrp_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = rrp_pkg::ST_RESULT;
            end
         end
         rrp_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, wrap_ff, best_wide[2:0], victim_wide[2:0]};
               state_in     = rrp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrp_pkg::ST_IDLE;
         end
      endcase
   end

   // counter moves only when a stamp is written or cleared
   `RRP_ASSERT_NEXT(a_ctr_only_on_update, !in_update, $stable(ctr_ff))
   // clear empties every way and restarts the counter
   `RRP_ASSERT_NEXT(a_clear_empties, upd_clear, (valid_ff == '0) && (ctr_ff == '0))
   // an out-of-range reference leaves all stamps alone
   `RRP_ASSERT_NEXT(a_bad_way_ignored, upd_bad_ref, $stable(valid_ff) && $stable(ctr_ff))
   // a result appears only out of the result state
   `RRP_ASSERT_NOW(a_rsp_from_result, $rose(rsp_valid_ff), $past(state_ff) == rrp_pkg::ST_RESULT)
   // scan counter never runs past the way count
   `RRP_ASSERT_NOW(a_cnt_bounded, scanning, cnt_ff <= CW'(WAYS))

endmodule

// File: dv/tb_recency_replacement_policy.sv
`timescale 1ns / 1ps

module tb_recency_replacement_policy;

   localparam int WAY_COUNT     = 8;
   localparam int STAMP_W       = 32;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct packed {
      logic [2:0] victim_way;
      logic [2:0] next_way;
      logic       stamp_wrapped;
   } evict_result_type;

   typedef struct {
      bit               mode_write;
      logic             mode;
      rrp_pkg::cmd_type cmd;
      logic [2:0]       way;
   } pending_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [1:0] req_tuser  = rrp_pkg::CMD_NONE;   // cmd[1:0]
   logic [7:0] req_tdata  = 8'h00;      // way[2:0], zero pad[7:3]
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;               // victim_way[2:0], next_way[5:3], stamp_wrapped[6]
   logic       csr_we     = 1'b0;
   logic       csr_wdata  = 1'b0;       // select_mode

   recency_replacement_policy #(
      .WAYS       (WAY_COUNT),
      .STAMP_BITS (STAMP_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   logic [STAMP_W-1:0] way_stamp [WAY_COUNT];
   logic [STAMP_W-1:0] access_tick;
   logic               mru_mode;

   evict_result_type outcome_q [$];
   pending_type      pending_q [$];

   int mismatches  = 0;
   int ref_count   = 0;
   int evict_count = 0;
   int mru_evicts  = 0;
   int clear_count = 0;
   int idle_count  = 0;
   int wrap_count  = 0;
   int mode_writes = 0;
   int checked     = 0;

   function automatic void clear_stamps();
      for (int i = 0; i < WAY_COUNT; i++) way_stamp[i] = '0;
      access_tick = '0;
   endfunction

   // Lowest way holding the oldest stamp, or the newest in MRU mode.
   function automatic logic [2:0] pick_way();
      int best;
      best = 0;
      for (int i = 1; i < WAY_COUNT; i++) begin
         if (mru_mode ? (way_stamp[i] > way_stamp[best]) : (way_stamp[i] < way_stamp[best]))
            best = i;
      end
      return best[2:0];
   endfunction

   function automatic logic stamp_and_advance(logic [2:0] w);
      way_stamp[w] = access_tick;
      access_tick  = access_tick + STAMP_W'(1);
      return access_tick == '0;
   endfunction

   function automatic void predict_eviction(rrp_pkg::cmd_type cmd, logic [2:0] way);
      evict_result_type r;
      r = '0;
      case (cmd)
         rrp_pkg::CMD_REF: begin
            ref_count++;
            r.stamp_wrapped = stamp_and_advance(way);
         end
         rrp_pkg::CMD_EVICT: begin
            evict_count++;
            if (mru_mode) mru_evicts++;
            r.victim_way    = pick_way();
            r.stamp_wrapped = stamp_and_advance(r.victim_way);
         end
         rrp_pkg::CMD_CLEAR: begin
            clear_count++;
            clear_stamps();
         end
         default: idle_count++;
      endcase
      r.next_way = pick_way();
      if (r.stamp_wrapped) wrap_count++;
      outcome_q.push_back(r);
   endfunction

   // Per-item wait, with occasional runs of back-to-back traffic.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic void note_failure(string msg);
      if (mismatches < 10) $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endfunction

   // ---------------------------------------------------------------- driver
   int          send_wait = 0;
   int          send_calm = 0;
   int          rsp_quiet = 0;
   logic        hold_req;
   logic        write_csr;
   pending_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_we     <= 1'b0;
         send_wait  = 0;
         rsp_quiet  = 0;
         mru_mode   = 1'b0;
         clear_stamps();
      end else begin
         hold_req  = req_tvalid && !req_tready;
         write_csr = 1'b0;
         if (rsp_tvalid && rsp_tready) rsp_quiet = 0;
         else rsp_quiet++;
         if (req_tvalid && req_tready) begin
            predict_eviction(rrp_pkg::cmd_type'(req_tuser), req_tdata[2:0]);
            send_wait = draw_wait(send_calm);
         end
         if (!hold_req) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_q.size() > 0) begin
               if (pending_q[0].mode_write) begin
                  // mode changes only once the block has drained
                  if (outcome_q.size() == 0 && rsp_quiet >= SETTLE_CYCLES) begin
                     write_csr = 1'b1;
                     csr_wdata <= pending_q[0].mode;
                     mru_mode  = pending_q[0].mode;
                     mode_writes++;
                     void'(pending_q.pop_front());
                  end
               end else begin
                  next_req  = pending_q.pop_front();
                  req_tuser <= next_req.cmd;
                  req_tdata <= {5'b0, next_req.way};
                  hold_req  = 1'b1;
               end
            end
         end
         req_tvalid <= hold_req;
         csr_we     <= write_csr;
      end
   end

   // ---------------------------------------------------------------- monitor
   int               recv_wait = 0;
   int               recv_calm = 0;
   evict_result_type got;
   evict_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.victim_way    = rsp_tdata[2:0];
            got.next_way      = rsp_tdata[5:3];
            got.stamp_wrapped = rsp_tdata[6];
            if (outcome_q.size() == 0) begin
               note_failure($sformatf("unexpected result tdata=%h", rsp_tdata));
            end else begin
               want = outcome_q.pop_front();
               checked++;
               if (got.victim_way !== want.victim_way || got.next_way !== want.next_way ||
                   got.stamp_wrapped !== want.stamp_wrapped)
                  note_failure($sformatf(
                     "result %0d: victim %0d/%0d next %0d/%0d wrapped %0b/%0b (exp/act)",
                     checked, want.victim_way, got.victim_way, want.next_way,
                     got.next_way, want.stamp_wrapped, got.stamp_wrapped));
            end
            recv_wait = draw_wait(recv_calm);
         end else if (rsp_tvalid && recv_wait > 0) begin
            recv_wait--;
         end
         rsp_tready <= (recv_wait == 0);
      end
   end

   // ---------------------------------------------------------------- watchdog
   int stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("no progress for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic void add_req(rrp_pkg::cmd_type cmd, logic [2:0] way);
      pending_type p;
      p.mode_write = 1'b0;
      p.mode       = 1'b0;
      p.cmd        = cmd;
      p.way        = way;
      pending_q.push_back(p);
   endfunction

   function automatic void add_mode(logic mode);
      pending_type p;
      p.mode_write = 1'b1;
      p.mode       = mode;
      p.cmd        = rrp_pkg::CMD_NONE;
      p.way        = '0;
      pending_q.push_back(p);
   endfunction

   initial begin
      int               pick;
      int               burst;
      rrp_pkg::cmd_type c;

      // LRU: fill every way, evict oldest twice, unused command, clear, tie on all zeros
      add_mode(1'b0);
      for (int w = 0; w < WAY_COUNT; w++) add_req(rrp_pkg::CMD_REF, w[2:0]);
      add_req(rrp_pkg::CMD_EVICT, 3'd7);
      add_req(rrp_pkg::CMD_EVICT, 3'd0);
      add_req(rrp_pkg::CMD_NONE, 3'd5);
      add_req(rrp_pkg::CMD_CLEAR, 3'd7);
      add_req(rrp_pkg::CMD_EVICT, 3'd0);
      // MRU: newest way is the victim; tie after clear goes to way 0
      add_mode(1'b1);
      add_req(rrp_pkg::CMD_REF, 3'd5);
      add_req(rrp_pkg::CMD_EVICT, 3'd0);
      add_req(rrp_pkg::CMD_REF, 3'd2);
      add_req(rrp_pkg::CMD_EVICT, 3'd7);
      add_req(rrp_pkg::CMD_NONE, 3'd0);
      add_req(rrp_pkg::CMD_CLEAR, 3'd0);
      add_req(rrp_pkg::CMD_EVICT, 3'd3);

      // random phases, alternating mode; clears kept rare so stamps spread out
      for (int ph = 0; ph < 6; ph++) begin
         add_mode(ph[0]);
         burst = $urandom_range(140, 190);
         for (int i = 0; i < burst; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) c = rrp_pkg::CMD_REF;
            else if (pick < 90) c = rrp_pkg::CMD_EVICT;
            else if (pick < 93) c = rrp_pkg::CMD_CLEAR;
            else c = rrp_pkg::CMD_NONE;
            add_req(c, 3'($urandom_range(0, 7)));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || req_tvalid || outcome_q.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (outcome_q.size() > 0)
         note_failure($sformatf("%0d results never arrived", outcome_q.size()));

      $display("checked %0d results: %0d reference, %0d evict (%0d in MRU), %0d clear, %0d unused",
               checked, ref_count, evict_count, mru_evicts, clear_count, idle_count);
      $display("mode writes %0d, counter wraps %0d, failures %0d",
               mode_writes, wrap_count, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
